[rtl/core/wda_pkg.sv]
// Types and constants for the windowed distance averager.
// Shared by the top level and the testbench; depends on nothing else.
`default_nettype none

package wda_pkg;

  localparam int NUM_AP_DEF = 8;
  localparam int WINDOW_DEF = 8;

  localparam int VALUE_W = 32;
  localparam int FILL_W  = 4;

  localparam int NUM_EST   = 3;
  localparam int EST_IFFT  = 0;
  localparam int EST_PHASE = 1;
  localparam int EST_RTT   = 2;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t                       command;
    logic [2:0]                 ap_index;
    logic signed [VALUE_W-1:0]  ifft_value;
    logic                       ifft_valid;
    logic signed [VALUE_W-1:0]  phase_value;
    logic                       phase_valid;
    logic signed [VALUE_W-1:0]  rtt_value;
    logic                       rtt_valid;
    logic                       end_of_report;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  ifft_average;
    logic signed [VALUE_W-1:0]  phase_average;
    logic signed [VALUE_W-1:0]  rtt_average;
    logic [FILL_W-1:0]          fill_count;
  } rsp_t;

  // one estimate as stored: valid flag over the Q16.16 value
  typedef struct packed {
    logic                       valid;
    logic signed [VALUE_W-1:0]  value;
  } est_t;

  typedef est_t [NUM_EST-1:0] entry_t;

endpackage

`default_nettype wire

[rtl/core/windowed_distance_averager_top.sv]
// Windowed distance averager: per-path ring of distance estimates with
// running-average queries. Depends on wda_pkg.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries store and query
//   words; response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   word per request, in order.
//   A store writes one path's entry at the current ring slot; with
//   end_of_report set it then advances the slot and the fill count. Its
//   response (zero averages, new fill count) is registered in the cycle after
//   accept, and the next request can be taken in that same cycle unless the response stalls.
//   A query walks the filled slots of one path through the entry memory,
//   one read per cycle, then divides the three sums by their counts in a
//   restoring divider, one quotient bit per cycle, the three estimates side
//   by side. The quotient is SUM_W bits wide, with SUM_W = 32 + clog2(WINDOW+1)
//   (36 at the default window of 8).
//   After reset the entry memory is cleared one entry per cycle, all
//   NUM_AP*WINDOW entries (64 by default); req_stall stays high meanwhile.
//   A stalled response holds in the output register and stalls the input;
//   a query under way finishes and waits. A query takes the next word once
//   its response has loaded and the state is back in idle.
`default_nettype none

module windowed_distance_averager_top
  import wda_pkg::*;
#(
  parameter int NUM_AP = NUM_AP_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int DEPTH  = NUM_AP * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = VALUE_W + $clog2(WINDOW + 1);
  localparam int DIV_CW = $clog2(SUM_W + 1);

  state_t              state, state_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic [SLOT_W-1:0]   write_slot;
  logic [CNT_W-1:0]    filled;
  logic [CNT_W-1:0]    fill_next;
  logic [ADDR_W-1:0]   base;
  logic [CNT_W-1:0]    walk_n;
  logic [CNT_W-1:0]    walk_idx;
  logic                pend;
  logic [DIV_CW-1:0]   div_cnt;

  entry_t              mem [DEPTH];
  entry_t              mem_q;
  entry_t              mem_wdata;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic                issue;

  logic                accept;
  logic                ap_ok;
  logic                is_store;
  logic                st_we;
  logic                rsp_load;
  logic [ADDR_W-1:0]   req_base;

  logic signed [SUM_W-1:0] sum  [NUM_EST];
  logic [CNT_W-1:0]        cnt  [NUM_EST];
  logic [SUM_W-1:0]        dvd  [NUM_EST];
  logic [CNT_W-1:0]        rem  [NUM_EST];
  logic                    neg  [NUM_EST];
  logic [SUM_W-1:0]        dvd_next [NUM_EST];
  logic [CNT_W-1:0]        rem_next [NUM_EST];
  logic [CNT_W:0]          trial    [NUM_EST];
  logic [SUM_W-1:0]        q_signed [NUM_EST];
  logic [VALUE_W-1:0]      avg      [NUM_EST];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && req.command == CMD_QUERY) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (walk_idx == walk_n && !pend) state_next = ST_PREP;
      end
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_CW'(SUM_W - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
    accept    = req_valid && !req_stall;
    ap_ok     = 5'(req.ap_index) < 5'(NUM_AP);
    is_store  = accept && req.command == CMD_STORE;
    st_we     = is_store && ap_ok;
    issue     = (state == ST_WALK) && (walk_idx != walk_n);
    mem_we    = st_we || (state == ST_CLEAR);
    rsp_load  = is_store || ((state == ST_DONE) && (!rsp_valid || !rsp_stall));
    req_base  = ADDR_W'(req.ap_index) * ADDR_W'(WINDOW);

    if (state == ST_CLEAR) begin
      mem_addr = clr_addr;
    end else if (state == ST_IDLE) begin
      mem_addr = req_base + ADDR_W'(write_slot);
    end else begin
      mem_addr = base + ADDR_W'(walk_idx[SLOT_W-1:0]);
    end

    if (state == ST_CLEAR) begin
      mem_wdata = '0;
    end else begin
      mem_wdata[EST_IFFT]  = '{valid: req.ifft_valid,  value: req.ifft_value};
      mem_wdata[EST_PHASE] = '{valid: req.phase_valid, value: req.phase_value};
      mem_wdata[EST_RTT]   = '{valid: req.rtt_valid,   value: req.rtt_value};
    end

    fill_next = filled;
    if (is_store && req.end_of_report && filled < CNT_W'(WINDOW)) begin
      fill_next = filled + CNT_W'(1);
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (issue) mem_q <= mem[mem_addr];
  end

  // divider step and final sign
  always_comb begin
    for (int j = 0; j < NUM_EST; j++) begin
      trial[j] = {rem[j], dvd[j][SUM_W-1]};
      if (trial[j] >= {1'b0, cnt[j]}) begin
        rem_next[j] = CNT_W'(trial[j] - {1'b0, cnt[j]});
        dvd_next[j] = {dvd[j][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[j] = trial[j][CNT_W-1:0];
        dvd_next[j] = {dvd[j][SUM_W-2:0], 1'b0};
      end
      q_signed[j] = neg[j] ? -dvd[j] : dvd[j];
      avg[j]      = (cnt[j] == '0) ? '0 : q_signed[j][VALUE_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      write_slot <= '0;
      filled     <= '0;
      rsp_valid  <= 1'b0;
      walk_idx   <= '0;
      pend       <= 1'b0;
      div_cnt    <= '0;
    end else begin
      state  <= state_next;
      filled <= fill_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (is_store && req.end_of_report) begin
        write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + SLOT_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        walk_idx <= '0;
        pend     <= 1'b0;
      end else if (state == ST_WALK) begin
        pend <= issue;
        if (issue) walk_idx <= walk_idx + CNT_W'(1);
      end
      if (state == ST_PREP) begin
        div_cnt <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + DIV_CW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      base   <= req_base;
      walk_n <= ap_ok ? filled : '0;
    end
    for (int j = 0; j < NUM_EST; j++) begin
      if (accept) begin
        sum[j] <= '0;
        cnt[j] <= '0;
      end else if (state == ST_WALK && pend && mem_q[j].valid) begin
        sum[j] <= sum[j] + {{(SUM_W - VALUE_W){mem_q[j].value[VALUE_W-1]}}, mem_q[j].value};
        cnt[j] <= cnt[j] + CNT_W'(1);
      end
      if (state == ST_PREP) begin
        neg[j] <= sum[j][SUM_W-1];
        dvd[j] <= sum[j][SUM_W-1] ? SUM_W'(-sum[j]) : SUM_W'(sum[j]);
        rem[j] <= '0;
      end else if (state == ST_DIV) begin
        dvd[j] <= dvd_next[j];
        rem[j] <= rem_next[j];
      end
    end
    if (rsp_load) begin
      if (is_store) begin
        rsp.ifft_average  <= '0;
        rsp.phase_average <= '0;
        rsp.rtt_average   <= '0;
        rsp.fill_count    <= FILL_W'(fill_next);
      end else begin
        rsp.ifft_average  <= avg[EST_IFFT];
        rsp.phase_average <= avg[EST_PHASE];
        rsp.rtt_average   <= avg[EST_RTT];
        rsp.fill_count    <= FILL_W'(filled);
      end
    end
  end

endmodule

`default_nettype wire

[tb/tb_windowed_distance_averager_top.sv]
// Testbench for windowed_distance_averager_top: directed and random report
// streams, with response words checked against a behavioral window model.
// Depends on wda_pkg and the top level only.
`timescale 1ns / 100ps

module tb_windowed_distance_averager_top;
  import wda_pkg::*;

  localparam int AP_N  = NUM_AP_DEF;
  localparam int WIN_N = WINDOW_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  windowed_distance_averager_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // window model
  est_t        win_est [NUM_EST][AP_N*WIN_N];
  int unsigned win_slot;
  int unsigned win_fill;

  rsp_t        pending_rsp[$];
  int unsigned mismatch_count = 0;
  int unsigned sent_words = 0;
  bit          quiet = 1'b0;
  int unsigned stall_hold = 0;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] path_mean(int est, int ap);
    longint total;
    longint hits;
    longint q;
    total = 0;
    hits = 0;
    for (int i = 0; i < win_fill && i < WIN_N; i++) begin
      if (win_est[est][ap*WIN_N+i].valid) begin
        total += longint'($signed(win_est[est][ap*WIN_N+i].value));
        hits++;
      end
    end
    if (hits == 0) return '0;
    q = total / hits;
    return q[VALUE_W-1:0];
  endfunction

  function automatic rsp_t window_response(req_t w);
    rsp_t r;
    int   idx;
    r = '0;
    if (w.command == CMD_STORE) begin
      if (w.ap_index < AP_N && win_slot < WIN_N) begin
        idx = w.ap_index * WIN_N + win_slot;
        win_est[EST_IFFT][idx]  = '{valid: w.ifft_valid,  value: w.ifft_value};
        win_est[EST_PHASE][idx] = '{valid: w.phase_valid, value: w.phase_value};
        win_est[EST_RTT][idx]   = '{valid: w.rtt_valid,   value: w.rtt_value};
      end
      if (w.end_of_report) begin
        win_slot = (win_slot + 1) % WIN_N;
        if (win_fill < WIN_N) win_fill++;
      end
    end else if (w.ap_index < AP_N) begin
      r.ifft_average  = path_mean(EST_IFFT, w.ap_index);
      r.phase_average = path_mean(EST_PHASE, w.ap_index);
      r.rtt_average   = path_mean(EST_RTT, w.ap_index);
    end
    r.fill_count = win_fill[FILL_W-1:0];
    return r;
  endfunction

  function automatic req_t make_word(cmd_t c, int ap, logic [31:0] v0, bit ok0,
                                     logic [31:0] v1, bit ok1, logic [31:0] v2,
                                     bit ok2, bit eor);
    req_t w;
    w.command       = c;
    w.ap_index      = ap[2:0];
    w.ifft_value    = v0;
    w.ifft_valid    = ok0;
    w.phase_value   = v1;
    w.phase_valid   = ok1;
    w.rtt_value     = v2;
    w.rtt_valid     = ok2;
    w.end_of_report = eor;
    return w;
  endfunction

  function automatic logic [31:0] rand_estimate();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'h0;
        endcase
      end
      1, 2, 3: v = $urandom;
      4: v = -$urandom_range(0, 40 << 16);
      default: v = $urandom_range(0, 40 << 16);
    endcase
    return v;
  endfunction

  function automatic req_t rand_store(int ap, bit eor);
    return make_word(CMD_STORE, ap,
                     rand_estimate(), $urandom_range(0, 9) != 0,
                     rand_estimate(), $urandom_range(0, 9) != 0,
                     rand_estimate(), $urandom_range(0, 9) != 0, eor);
  endfunction

  function automatic req_t rand_query();
    return make_word(CMD_QUERY, $urandom_range(0, AP_N-1),
                     $urandom, 1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                     $urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
  endfunction

  task automatic send_word(input req_t w);
    int unsigned gap;
    pending_rsp.push_back(window_response(w));
    sent_words++;
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // response side back-pressure
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (quiet) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall  <= $urandom_range(0, 3) == 0;
      stall_hold <= gap_len();
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : rsp_checker
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (pending_rsp.size() == 0) begin
        $error("response word with none outstanding: %h", rsp);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("ifft_average", want.ifft_average, rsp.ifft_average);
        check_field("phase_average", want.phase_average, rsp.phase_average);
        check_field("rtt_average", want.rtt_average, rsp.rtt_average);
        check_field("fill_count", 32'(want.fill_count), 32'(rsp.fill_count));
      end
    end
  end

  task automatic test_empty_window();
    send_word(make_word(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_QUERY, 7, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1,
                        32'hFFFF_FFFF, 1, 1));
    send_word(make_word(CMD_STORE, 3, 5 << 16, 1, 6 << 16, 1, 7 << 16, 1, 0));
    send_word(make_word(CMD_QUERY, 3, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_value_extremes();
    send_word(make_word(CMD_STORE, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1,
                        32'h7FFF_FFFF, 1, 0));
    send_word(make_word(CMD_STORE, 1, 32'h8000_0000, 1, 32'h8000_0000, 1,
                        32'h8000_0000, 1, 0));
    send_word(make_word(CMD_STORE, 2, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 0,
                        32'h8000_0000, 0, 1));
    send_word(make_word(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_QUERY, 1, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_QUERY, 2, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_QUERY, 5, 0, 0, 0, 0, 0, 0, 0));
    // negative sums must truncate toward zero
    send_word(make_word(CMD_STORE, 0, 32'h8000_0000, 1, 32'h8000_0000, 1,
                        32'h8000_0000, 1, 1));
    send_word(make_word(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_STORE, 0, -3, 1, 3, 1, 1, 1, 1));
    send_word(make_word(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1));
  endtask

  task automatic test_window_wrap();
    for (int k = 0; k < WIN_N + 1; k++)
      send_word(make_word(CMD_STORE, 4, k << 16, 1, -(k << 16), 1, k, k[0], 1));
    send_word(make_word(CMD_QUERY, 4, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_report_stream(int unsigned n_words);
    int unsigned stop_at;
    int unsigned reports;
    bit          used [AP_N];
    int          last_ap;
    stop_at = sent_words + n_words;
    reports = 0;
    while (sent_words < stop_at) begin
      if (reports % 20 == 0) quiet = $urandom_range(0, 2) == 0;
      reports++;
      last_ap = -1;
      for (int ap = 0; ap < AP_N; ap++) begin
        used[ap] = $urandom_range(0, 3) != 0;
        if (used[ap]) last_ap = ap;
      end
      if (last_ap < 0) begin
        last_ap = $urandom_range(0, AP_N-1);
        used[last_ap] = 1'b1;
      end
      for (int ap = 0; ap <= last_ap; ap++) begin
        if (used[ap]) send_word(rand_store(ap, ap == last_ap));
        if ($urandom_range(0, 5) == 0) send_word(rand_query());
      end
      repeat ($urandom_range(1, 3)) send_word(rand_query());
    end
  endtask

  task automatic test_broken_sequences(int unsigned n_words);
    req_t w;
    quiet = 1'b0;
    repeat (n_words) begin
      if ($urandom_range(0, 1) == 0) begin
        w = rand_store($urandom_range(0, AP_N-1), $urandom_range(0, 3) == 0);
      end else begin
        w = rand_query();
      end
      send_word(w);
    end
  endtask

  initial begin
    for (int e = 0; e < NUM_EST; e++)
      for (int i = 0; i < AP_N*WIN_N; i++)
        win_est[e][i] = '0;
    win_slot = 0;
    win_fill = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_window();
    test_value_extremes();
    test_window_wrap();
    test_report_stream(1300);
    test_broken_sequences(250);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
